// File: rtl/core/depq_pkg.sv
// Shared types, codes and sizing constants for the double-ended priority queue.
package depq_pkg;

  localparam int CAPACITY = 1024;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 20;
  localparam int PRIO_W   = 24;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;

  // Probe reduction tree: each node ORs up to FANIN children
  localparam int FANIN = 32;
  localparam int FAN_W = $clog2(FANIN);

  localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP_MAX = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP_MIN = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_POPPED    = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   client_id;
    logic [PRIO_W-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]     popped_id;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic            hit;
    logic [ID_W-1:0] id;
  } probe_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_SHIFT
  } depq_cmd_t;

  typedef struct packed {
    depq_cmd_t        cmd;
    logic             probe_max;
    entry_t           key;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] count_m1;
  } depq_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE
  } depq_state_t;

  // Node count at tree level l (level 0 is the row of cells)
  function automatic int lvl_width(int l);
    int w;
    w = CAPACITY;
    for (int k = 0; k < l; k++) begin
      w = (w + FANIN - 1) >> FAN_W;
    end
    return w;
  endfunction

  function automatic int num_levels();
    int w;
    int n;
    w = CAPACITY;
    n = 0;
    for (int k = 0; k < 8; k++) begin
      if (w > 1) begin
        w = (w + FANIN - 1) >> FAN_W;
        n = n + 1;
      end
    end
    return n;
  endfunction

  localparam int TREE_LEVELS = num_levels();

  // Start of level l inside the flat node array (levels 1 and up)
  function automatic int lvl_offset(int l);
    int off;
    off = 0;
    for (int k = 1; k < l; k++) begin
      off = off + lvl_width(k);
    end
    return off;
  endfunction

  localparam int TREE_NODES = lvl_offset(TREE_LEVELS + 1);
  localparam int WAIT_W     = $clog2(TREE_LEVELS + 1);

endpackage

// File: rtl/core/depq_cell.sv
// One slot of the sorted chain: holds an entry, compares and shifts with its neighbors.
module depq_cell
  import depq_pkg::*;
(
  input  logic             clk,
  input  depq_ctrl_t       ctrl,
  input  logic [CNT_W-1:0] cell_idx,
  input  entry_t           left_ent,
  input  logic             left_lt,
  input  entry_t           right_ent,
  output entry_t           ent,
  output logic             lt,
  output probe_t           probe
);

  entry_t ent_r;
  entry_t ent_nxt;
  logic   valid;

  assign valid = cell_idx < ctrl.count;
  assign lt    = valid && (ent_r.prio < ctrl.key.prio);
  assign ent   = ent_r;

  always_comb begin
    probe.hit = ctrl.probe_max ? (valid && (cell_idx == ctrl.count_m1))
                               : (valid && (ent_r.prio == ctrl.key.prio));
    probe.id  = probe.hit ? ent_r.id : '0;
  end

  always_comb begin
    ent_nxt = ent_r;
    case (ctrl.cmd)
      CMD_INSERT: begin
        // Smaller entries stay; the first slot not below the key takes it,
        // everything above moves up one
        if (!lt) begin
          ent_nxt = left_lt ? ctrl.key : left_ent;
        end
      end
      CMD_SHIFT: ent_nxt = right_ent;
      default:   ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// File: rtl/core/depq_tree.sv
// Registered OR tree that gathers the one-hot probe hits of all cells.
module depq_tree
  import depq_pkg::*;
(
  input  logic   clk,
  input  probe_t leaves [CAPACITY],
  output probe_t root
);

  probe_t node_r [TREE_NODES];

  for (genvar l = 1; l <= TREE_LEVELS; l++) begin : g_lvl
    for (genvar j = 0; j < lvl_width(l); j++) begin : g_node
      probe_t kids [FANIN];
      probe_t acc;

      for (genvar k = 0; k < FANIN; k++) begin : g_kid
        if (j * FANIN + k >= lvl_width(l - 1)) begin : g_none
          assign kids[k] = '0;
        end else if (l == 1) begin : g_leaf
          assign kids[k] = leaves[j * FANIN + k];
        end else begin : g_inner
          assign kids[k] = node_r[lvl_offset(l - 1) + j * FANIN + k];
        end
      end

      always_comb begin
        acc = '0;
        for (int k = 0; k < FANIN; k++) begin
          acc = acc | kids[k];
        end
      end

      always_ff @(posedge clk) begin
        node_r[lvl_offset(l) + j] <= acc;
      end
    end
  end

  assign root = node_r[TREE_NODES - 1];

endmodule

// File: rtl/core/double_ended_priority_queue.sv
// Double-ended priority queue built as a sorted chain of cells.
// An accepted item is held while the registered probe OR tree settles; its result is then registered.
// A new item is taken only once the previous one has been decided and the queue is idle again.
// The next item is taken while the previous result waits in the output register.
// Reset clears the entry count and control state; cell contents stay undefined.
module double_ended_priority_queue
  import depq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  depq_state_t      state_r;
  depq_state_t      state_nxt;
  logic [WAIT_W-1:0] wait_r;
  logic [WAIT_W-1:0] wait_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  in_item_t         req_r;
  logic             out_valid_r;
  out_item_t        out_data_r;
  out_item_t        result;
  logic             in_fire;
  logic             decide_fire;
  depq_cmd_t        cmd;

  depq_ctrl_t       ctrl;
  entry_t           ents   [CAPACITY];
  logic             lts    [CAPACITY];
  probe_t           probes [CAPACITY];
  probe_t           root;

  assign in_fire     = in_valid && in_ready;
  assign decide_fire = (state_r == ST_DECIDE) && (!out_valid_r || out_ready);

  always_comb begin
    ctrl.cmd       = cmd;
    ctrl.probe_max = (req_r.kind == KIND_POP_MAX);
    ctrl.key.prio  = req_r.priority_req;
    ctrl.key.id    = req_r.client_id;
    ctrl.count     = count_r;
    ctrl.count_m1  = count_r - CNT_W'(1);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_ent;
    logic   left_lt;
    entry_t right_ent;

    if (i == 0) begin : g_head
      assign left_ent = ctrl.key;
      assign left_lt  = 1'b1;
    end else begin : g_body
      assign left_ent = ents[i - 1];
      assign left_lt  = lts[i - 1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_ent = ents[i];
    end else begin : g_next
      assign right_ent = ents[i + 1];
    end

    depq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cell_idx  (CNT_W'(i)),
      .left_ent  (left_ent),
      .left_lt   (left_lt),
      .right_ent (right_ent),
      .ent       (ents[i]),
      .lt        (lts[i]),
      .probe     (probes[i])
    );
  end

  depq_tree u_tree (
    .clk    (clk),
    .leaves (probes),
    .root   (root)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    wait_nxt  = wait_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_SEARCH;
          wait_nxt  = '0;
        end
      end
      ST_SEARCH: begin
        // Wait for the probe tree to settle on the held request
        if (wait_r == WAIT_W'(TREE_LEVELS - 1)) begin
          state_nxt = ST_DECIDE;
        end else begin
          wait_nxt = wait_r + WAIT_W'(1);
        end
      end
      ST_DECIDE: begin
        if (decide_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the state machine: handshake, cell command, result
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    cmd       = CMD_HOLD;
    count_nxt = count_r;
    result    = '0;
    case (req_r.kind)
      KIND_INSERT: begin
        if (count_r == CNT_W'(CAPACITY)) begin
          result.status = STATUS_FULL;
        end else if (root.hit) begin
          result.status = STATUS_DUPLICATE;
        end else begin
          result.status = STATUS_INSERTED;
          cmd           = CMD_INSERT;
          count_nxt     = count_r + CNT_W'(1);
        end
      end
      KIND_POP_MAX: begin
        if (count_r == '0) begin
          result.status = STATUS_EMPTY;
        end else begin
          result.status    = STATUS_POPPED;
          result.popped_id = root.id;
          count_nxt        = count_r - CNT_W'(1);
        end
      end
      default: begin
        // Pop lowest (also any unknown kind): take the head and move every entry down one slot
        if (count_r == '0) begin
          result.status = STATUS_EMPTY;
        end else begin
          result.status    = STATUS_POPPED;
          result.popped_id = ents[0].id;
          cmd              = CMD_SHIFT;
          count_nxt        = count_r - CNT_W'(1);
        end
      end
    endcase
    if (!decide_fire) begin
      cmd       = CMD_HOLD;
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wait_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
      count_r <= count_nxt;
      if (decide_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_data;
    end
    if (decide_fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
